@@ hdl/page_packed_frame_buffer_defines.svh @@
// Assertion macros used by the back part of the frame buffer RTL.
// Taken in by `include; relies on nothing else.
`ifndef PAGE_PACKED_FRAME_BUFFER_DEFINES_SVH
`define PAGE_PACKED_FRAME_BUFFER_DEFINES_SVH

// Check a property on every rising clock edge outside of reset.
`define PPFB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("ppfb: assertion failed");

// Check that a condition never holds outside of reset.
`define PPFB_NEVER(lbl, clk, rst_n, cond) \
  `PPFB_ASSERT(lbl, clk, rst_n, !(cond))

`endif

@@ hdl/ppfb_pkg.sv @@
// Types and constants of the page-packed frame buffer.
// Used by the front, queue, back and top modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ppfb_pkg;

  // Widest store address: 256 columns by 16 pages
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PAGE_ROWS   = 8;
  localparam logic [7:0]  FILL_ONES   = 8'hFF;
  localparam logic [7:0]  FILL_ZEROS  = 8'h00;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    COL_BLACK   = 2'd0,
    COL_WHITE   = 2'd1,
    COL_INVERSE = 2'd2,
    COL_NONE    = 2'd3
  } colour_e;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    colour_e            colour;
    logic [9:0]         byte_index;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       clipped;
  } result_t;

  // Classified command kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_SKIP = 2'd0,
    CMD_DRAW = 2'd1,
    CMD_READ = 2'd2,
    CMD_FILL = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [ADDR_W-1:0] addr;
    colour_e           colour;
    logic [2:0]        bit_sel;
    logic              clipped;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_INIT = 2'd0,
    BK_IDLE = 2'd1,
    BK_RMW  = 2'd2,
    BK_FILL = 2'd3
  } back_state_e;

  // Status from the back part to the handshake logic
  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

`default_nettype wire

@@ hdl/ppfb_front.sv @@
// Front part: accepts items and classifies them into store commands.
// Depends on ppfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppfb_front import ppfb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic  start,
  input  logic  busy,
  input  item_t item_i,
  output logic  push_o,
  output cmd_t  cmd_o
);

  localparam int unsigned Pages      = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int unsigned StoreBytes = SCREEN_WIDTH * Pages;

  logic        x_on, y_on, read_ok;
  logic [14:0] x_mag, y_mag;
  logic [ADDR_W-1:0] pix_addr;

  // Accept an item whenever start is high and busy is low
  assign push_o = start & ~busy;

  // Check the screen bounds and form the page-packed byte address
  assign x_mag    = item_i.pixel_x[14:0];
  assign y_mag    = item_i.pixel_y[14:0];
  assign x_on     = !item_i.pixel_x[15] && ({1'b0, x_mag} < 16'(SCREEN_WIDTH));
  assign y_on     = !item_i.pixel_y[15] && ({1'b0, y_mag} < 16'(SCREEN_HEIGHT));
  assign pix_addr = ADDR_W'(x_mag) + ADDR_W'(y_mag >> 3) * ADDR_W'(SCREEN_WIDTH);
  assign read_ok  = {3'b000, item_i.byte_index} < 13'(StoreBytes);

  // Classify the item
  always_comb begin
    cmd_o         = '0;
    cmd_o.kind    = CMD_SKIP;
    cmd_o.colour  = item_i.colour;
    cmd_o.bit_sel = item_i.pixel_y[2:0];
    unique case (item_i.op)
      OP_DRAW: begin
        cmd_o.addr = pix_addr;
        if (!(x_on && y_on)) begin
          cmd_o.clipped = 1'b1;
        end else if (item_i.colour != COL_NONE) begin
          cmd_o.kind = CMD_DRAW;
        end
      end
      OP_CLEAR: begin
        if (item_i.colour inside {COL_BLACK, COL_WHITE}) begin
          cmd_o.kind = CMD_FILL;
        end
      end
      OP_READ: begin
        cmd_o.addr = ADDR_W'(item_i.byte_index);
        if (read_ok) begin
          cmd_o.kind = CMD_READ;
        end
      end
      default: begin
        cmd_o.kind = CMD_SKIP;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/ppfb_queue.sv @@
// Short command queue between the front and back parts.
// Depends on ppfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppfb_queue import ppfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slot_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ppfb_back.sv @@
// Back part: owns the frame store, runs pixel updates, reads and fill sweeps.
// Depends on ppfb_pkg and page_packed_frame_buffer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "page_packed_frame_buffer_defines.svh"

module ppfb_back import ppfb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output back_stat_t stat_o,
  output logic       done_o,
  output result_t    result_o
);

  localparam int unsigned Pages      = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int unsigned StoreBytes = SCREEN_WIDTH * Pages;
  localparam int unsigned AW         = $clog2(StoreBytes);
  localparam logic [AW-1:0] LastAddr = AW'(StoreBytes - 1);

  back_state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [7:0]    fill_q, fill_d;
  logic          done_q, done_d;
  result_t       res_q, res_d;
  cmd_t          cur_q;
  logic          ld_cur;
  logic [7:0]    rd_q;
  logic [7:0]    mem_q [StoreBytes];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, pix_mask, pix_byte;

  // Apply the pixel operation to the fetched byte
  assign pix_mask = 8'(1) << cur_q.bit_sel;
  always_comb begin
    case (cur_q.colour)
      COL_BLACK:   pix_byte = rd_q & ~pix_mask;
      COL_WHITE:   pix_byte = rd_q | pix_mask;
      COL_INVERSE: pix_byte = rd_q ^ pix_mask;
      default:     pix_byte = rd_q;
    endcase
  end

  assign mem_raddr = cmd_i.addr[AW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_INIT: if (cnt_q == LastAddr) state_d = BK_IDLE;
      BK_IDLE: begin
        if (!empty_i) begin
          case (cmd_i.kind) inside
            CMD_DRAW, CMD_READ: state_d = BK_RMW;
            CMD_FILL:           state_d = BK_FILL;
            default:            state_d = BK_IDLE;
          endcase
        end
      end
      BK_RMW:  state_d = BK_IDLE;
      BK_FILL: if (cnt_q == LastAddr) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    pop_o     = 1'b0;
    ld_cur    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = fill_q;
    cnt_d     = cnt_q;
    fill_d    = fill_q;
    done_d    = 1'b0;
    res_d     = '0;
    unique case (state_q)
      BK_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = FILL_ZEROS;
        cnt_d     = cnt_q + 1'b1;
      end
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          ld_cur = 1'b1;
          case (cmd_i.kind)
            CMD_SKIP: begin
              done_d        = 1'b1;
              res_d.clipped = cmd_i.clipped;
            end
            CMD_FILL: begin
              cnt_d  = '0;
              fill_d = (cmd_i.colour == COL_WHITE) ? FILL_ONES : FILL_ZEROS;
            end
            default: ;
          endcase
        end
      end
      BK_RMW: begin
        done_d = 1'b1;
        if (cur_q.kind == CMD_DRAW) begin
          mem_we    = 1'b1;
          mem_waddr = cur_q.addr[AW-1:0];
          mem_wdata = pix_byte;
        end else begin
          res_d.read_data = rd_q;
        end
      end
      BK_FILL: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LastAddr) begin
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_INIT;
      cnt_q   <= '0;
      fill_q  <= FILL_ZEROS;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
    end
  end

  // Hold the current command and the result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (ld_cur) begin
      cur_q <= cmd_i;
    end
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  assign stat_o.init_busy = (state_q == BK_INIT);
  assign done_o           = done_q;
  assign result_o         = res_q;

  `PPFB_NEVER(a_pop_empty, clk_i, rst_ni, pop_o && empty_i)
  `PPFB_ASSERT(a_rmw_done, clk_i, rst_ni, (state_q == BK_RMW) |=> done_o)
  `PPFB_ASSERT(a_init_quiet, clk_i, rst_ni, (state_q == BK_INIT) |=> !done_o)
  `PPFB_ASSERT(a_sweep_step, clk_i, rst_ni,
    (state_q == BK_FILL && cnt_q != LastAddr) |=> (cnt_q == AW'($past(cnt_q) + 1'b1)))

endmodule

`default_nettype wire

@@ hdl/page_packed_frame_buffer.sv @@
// Top level of the page-packed monochrome frame buffer.
// Depends on ppfb_pkg, ppfb_front, ppfb_queue and ppfb_back.
//
// Usage:
//   Input channel: drive item_i and raise start; the item is taken at a
//   rising edge where start is high and busy is low. Items are draw pixel,
//   clear fill and read byte.
//   Result channel: every item gives one result on result_o, shown for one
//   cycle with done_o high. The receiver cannot stall; results are in item
//   order.
//   Flow: the back part runs one command at a time from a two-entry
//   queue. A draw or read is popped in the idle state, where the store
//   read is issued, and writes back or reports in the read-modify-write
//   state; its result is registered. Items that need no store access
//   report from the idle state through that register. A clear fill sweeps
//   the store one byte per cycle over SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8)
//   bytes (1024 at the defaults) and reports at the end of the sweep; the
//   back part takes no new command until then.
//   Reset: the store is cleared by a sweep of the same length; busy stays
//   high until it finishes.
`timescale 1ns / 1ps
`default_nettype none

module page_packed_frame_buffer import ppfb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  logic       push, pop, full, empty;
  cmd_t       front_cmd, queue_cmd;
  back_stat_t back_stat;

  // Stall the input while the queue is full or the store is being cleared
  assign busy = full | back_stat.init_busy;

  ppfb_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .start (start),
    .busy  (busy),
    .item_i(item_i),
    .push_o(push),
    .cmd_o (front_cmd)
  );

  ppfb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .full_o (full),
    .empty_o(empty),
    .cmd_o  (queue_cmd)
  );

  ppfb_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (queue_cmd),
    .pop_o   (pop),
    .stat_o  (back_stat),
    .done_o  (done_o),
    .result_o(result_o)
  );

endmodule

`default_nettype wire
